### sv/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg: shared constants and tables for leg inverse kinematics
// Field widths, reset values and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lik_pkg;

	localparam int COORD_W           = 16;
	localparam int IN_W              = 6 * COORD_W;
	localparam int YAW_W             = 15;
	localparam int PITCH_W           = 14;
	localparam int KNEE_W            = 14;
	localparam int OUT_W             = 48;
	localparam int USER_W            = 1;
	localparam int SEG_W             = 13;
	localparam logic [SEG_W-1:0] SEG_RESET = 13'd2048;
	localparam int DEF_FRAC_BITS     = 12;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int IO_FRAC           = 12;
	localparam int PI_Q12            = 12868;
	localparam int HALF_PI_Q12       = 6434;
	localparam logic signed [63:0] HALF_PI_Q30 = 64'sh6487ED51;
	// horizontal length square root: 25 result bits over a 50-bit radicand
	localparam int H_BITS            = 25;

	function automatic logic signed [63:0] atan_q30(input int i);
		logic signed [63:0] t;
		case (i)
			0:  t = 64'sh3243F6A8;
			1:  t = 64'sh1DAC6705;
			2:  t = 64'sh0FADBAFC;
			3:  t = 64'sh07F56EA6;
			4:  t = 64'sh03FEAB76;
			5:  t = 64'sh01FFD55B;
			6:  t = 64'sh00FFFAAA;
			7:  t = 64'sh007FFF55;
			8:  t = 64'sh003FFFEA;
			9:  t = 64'sh001FFFFD;
			10: t = 64'sh000FFFFF;
			11: t = 64'sh0007FFFF;
			12: t = 64'sh0003FFFF;
			13: t = 64'sh0001FFFF;
			14: t = 64'sh0000FFFF;
			15: t = 64'sh00007FFF;
			16: t = 64'sh00003FFF;
			17: t = 64'sh00001FFF;
			18: t = 64'sh00000FFF;
			19: t = 64'sh000007FF;
			20: t = 64'sh000003FF;
			21: t = 64'sh000001FF;
			22: t = 64'sh000000FF;
			23: t = 64'sh0000007F;
			default: t = 64'sh0;
		endcase
		return t;
	endfunction

	// round a Q.30 angle half up to frac fractional bits
	function automatic logic signed [63:0] q30_to_frac(input logic signed [63:0] t,
			input int frac);
		return (t + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
	endfunction

	function automatic logic signed [63:0] atan_step(input int i, input int frac);
		return q30_to_frac(atan_q30(i), frac);
	endfunction

endpackage

### sv/lik_delay.sv
// ----------------------------------------------------------------------------
// lik_delay: enable-gated delay line
// Shifts a word through DEPTH registers, advancing only when en is high.
// ----------------------------------------------------------------------------
module lik_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];
endmodule

### sv/lik_div_cell.sv
// ----------------------------------------------------------------------------
// lik_div_cell: one quotient bit of a restoring divider
// Subtract the shifted divisor when it fits and set quotient bit K.
// ----------------------------------------------------------------------------
module lik_div_cell #(
	parameter int RW = 40,
	parameter int DW = 27,
	parameter int QW = 13,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_in,
	input  logic [DW-1:0] d_in,
	input  logic [QW-1:0] q_in,
	output logic [RW-1:0] rem_out,
	output logic [DW-1:0] d_out,
	output logic [QW-1:0] q_out
);
	logic [RW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [QW-1:0] q_q;
	logic [RW-1:0] dk;
	logic [RW-1:0] rem_n;
	logic [QW-1:0] q_n;

	always_comb begin
		dk = RW'(d_in) << K;
		if (rem_in >= dk) begin
			rem_n = rem_in - dk;
			q_n   = q_in | (QW'(1) << K);
		end else begin
			rem_n = rem_in;
			q_n   = q_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_n;
			d_q   <= d_in;
			q_q   <= q_n;
		end
	end

	assign rem_out = rem_q;
	assign d_out   = d_q;
	assign q_out   = q_q;
endmodule

### sv/lik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lik_sqrt_cell: one result bit of a restoring integer square root
// Trial-subtract root plus the current bit weight, then shift the root.
// ----------------------------------------------------------------------------
module lik_sqrt_cell #(
	parameter int NB = 25,
	parameter int K  = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*NB-1:0] v_in,
	input  logic [2*NB-1:0] r_in,
	output logic [2*NB-1:0] v_out,
	output logic [2*NB-1:0] r_out
);
	localparam int VW = 2 * NB;

	logic [VW-1:0] v_q;
	logic [VW-1:0] r_q;
	logic [VW-1:0] bitv;
	logic [VW:0]   sum;
	logic [VW-1:0] v_n;
	logic [VW-1:0] r_n;

	always_comb begin
		bitv = VW'(1) << (2 * (NB - 1 - K));
		sum  = {1'b0, r_in} + {1'b0, bitv};
		if ({1'b0, v_in} >= sum) begin
			v_n = v_in - sum[VW-1:0];
			r_n = (r_in >> 1) + bitv;
		end else begin
			v_n = v_in;
			r_n = r_in >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= v_n;
			r_q <= r_n;
		end
	end

	assign v_out = v_q;
	assign r_out = r_q;
endmodule

### sv/lik_cordic_cell.sv
// ----------------------------------------------------------------------------
// lik_cordic_cell: one micro-rotation of a vectoring CORDIC
// Rotate toward the x axis and accumulate the table angle of this stage.
// ----------------------------------------------------------------------------
module lik_cordic_cell #(
	parameter int CW    = 32,
	parameter int ZW    = 16,
	parameter int STAGE = 0,
	parameter int FRAC  = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic                 flag_in,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic                 flag_out
);
	import lik_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(STAGE, FRAC));

	logic signed [CW-1:0] x_q, y_q, xs, ys, x_n, y_n;
	logic signed [ZW-1:0] z_q, z_n;
	logic                 flag_q;

	always_comb begin
		xs = x_in >>> STAGE;
		ys = y_in >>> STAGE;
		if (y_in > 0) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + STEP;
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - STEP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_n;
			y_q    <= y_n;
			z_q    <= z_n;
			flag_q <= flag_in;
		end
	end

	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign flag_out = flag_q;
endmodule

### sv/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics: yaw, pitch and knee angles of a two-segment leg
// Fully pipelined chain of divider, square root and CORDIC cells.
// ----------------------------------------------------------------------------
// Send one shoulder/foot position pair per transfer on the s_ stream and
// collect yaw, pitch and knee angles (radians, Q3.12) on the m_ stream in the
// same order. The block takes a new item every cycle unless the output buffer
// is full. The knee path sets the pipeline depth: a bit-per-cell divider of
// FRAC_BITS+1 cells followed by a bit-per-cell square root of FRAC_BITS+9
// cells, then a CORDIC row of CORDIC_STAGES cells, one such row for each of
// the three angles. A two-entry output buffer sits between the pipeline and
// m_tready, so the input keeps taking items while one result waits; the whole
// pipeline holds only when both entries are full. Write segment_length on the
// cfg_ channel only while no item is in flight.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics #(
	parameter int FRAC_BITS     = lik_pkg::DEF_FRAC_BITS,
	parameter int CORDIC_STAGES = lik_pkg::DEF_CORDIC_STAGES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// shoulder_x, shoulder_y, shoulder_z, foot_x, foot_y, foot_z (16 bits each)
	input  logic [lik_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// yaw_angle[14:0], pitch_angle[28:15], knee_angle[42:29], zero fill
	output logic [lik_pkg::OUT_W-1:0]   m_tdata,
	// out_of_reach[0]
	output logic [lik_pkg::USER_W-1:0]  m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lik_pkg::SEG_W-1:0]   cfg_data
);
	import lik_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int NS     = CORDIC_STAGES;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 32;
	localparam int HXY_W  = 33;
	localparam int D2_W   = 34;
	localparam int NUM_W  = D2_W + 1;
	localparam int L2_W   = 2 * SEG_W;
	localparam int TL_W   = L2_W + 1;
	localparam int RW     = TL_W + F + 1;
	localparam int QW     = F + 1;
	localparam int ARG_W  = F + 2;
	localparam int KB     = F + 9;
	localparam int KVW    = 2 * KB;
	localparam int HVW    = 2 * H_BITS;
	localparam int LAT_K  = 2 * F + 12;
	localparam int CW     = ((H_BITS > KB) ? H_BITS : KB) + 3;
	localparam int ZW     = F + 4;
	localparam int TOT    = 4 + LAT_K + NS;
	localparam int SIDE_W = 3 * DIFF_W + 1;
	localparam int SH_DN  = (F > IO_FRAC) ? F - IO_FRAC : 0;
	localparam int SH_UP  = (F < IO_FRAC) ? IO_FRAC - F : 0;
	localparam int IOW    = ZW + 1 + SH_UP;
	localparam int RES_W  = YAW_W + PITCH_W + KNEE_W + 1;

	localparam logic signed [ARG_W-1:0] ONE_A  = ARG_W'(1) << F;
	localparam logic [2*F:0]            ONE2   = (2*F+1)'(1) << (2 * F);
	localparam logic signed [ZW-1:0]    HP_Z   = ZW'(q30_to_frac(HALF_PI_Q30, F));
	localparam logic signed [IOW-1:0]   RND_IO = IOW'((1 << SH_DN) >> 1);
	localparam logic signed [IOW-1:0]   PI_IO  = IOW'(PI_Q12);
	localparam logic signed [IOW-1:0]   HP_IO  = IOW'(HALF_PI_Q12);

	// ---------------- configuration and flow control ----------------
	logic [SEG_W-1:0] seg_q;
	logic [TOT-1:0]   v_q;
	logic [1:0]       cnt_q;
	logic             wr_q, rd_q;
	logic [RES_W-1:0] buf_q [2];
	logic             en, push, pop;
	logic [RES_W-1:0] res_c;

	assign cfg_ready = 1'b1;
	// hold the whole pipe only when the output buffer is full
	assign en       = ~cnt_q[1];
	assign s_tready = en;
	assign push     = en & v_q[TOT-1];
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (cfg_valid) begin
			seg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (en) begin
				v_q <= {v_q[TOT-2:0], s_tvalid};
			end
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_c;
		end
	end

	assign m_tdata = {{(OUT_W-RES_W+1){1'b0}}, buf_q[rd_q][RES_W-2:0]};
	assign m_tuser = buf_q[rd_q][RES_W-1];

	// ---------------- s1: difference vector, L^2 ----------------
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [L2_W-1:0]          l2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_W'($signed(s_tdata[63:48])) - DIFF_W'($signed(s_tdata[15:0]));
			dy_s1 <= DIFF_W'($signed(s_tdata[79:64])) - DIFF_W'($signed(s_tdata[31:16]));
			dz_s1 <= DIFF_W'($signed(s_tdata[95:80])) - DIFF_W'($signed(s_tdata[47:32]));
			l2_s1 <= seg_q * seg_q;
		end
	end

	// ---------------- s2: squares, 2L^2 ----------------
	logic signed [DIFF_W-1:0]   dx_s2, dy_s2, dz_s2;
	logic [SQ_W-1:0]            sqx_s2, sqy_s2, sqz_s2;
	logic [TL_W-1:0]            tl_s2;
	logic signed [2*DIFF_W-1:0] px_c, py_c, pz_c;

	always_comb begin
		px_c = dx_s1 * dx_s1;
		py_c = dy_s1 * dy_s1;
		pz_c = dz_s1 * dz_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			sqx_s2 <= px_c[SQ_W-1:0];
			sqy_s2 <= py_c[SQ_W-1:0];
			sqz_s2 <= pz_c[SQ_W-1:0];
			tl_s2  <= {l2_s1, 1'b0};
		end
	end

	// ---------------- s3: acos numerator, reach check ----------------
	logic [HXY_W-1:0]        hxy_c;
	logic [D2_W-1:0]         d2_c;
	logic signed [NUM_W-1:0] num_c, tl_ext, mag_c;
	logic                    reach_c, neg_c;
	logic [RW-1:0]           n_c;

	always_comb begin
		hxy_c   = HXY_W'(sqx_s2) + HXY_W'(sqy_s2);
		d2_c    = D2_W'(hxy_c) + D2_W'(sqz_s2);
		tl_ext  = $signed(NUM_W'(tl_s2));
		num_c   = $signed({1'b0, d2_c}) - tl_ext;
		reach_c = (tl_s2 == '0) || (num_c > tl_ext);
		neg_c   = num_c < 0;
		mag_c   = neg_c ? -num_c : num_c;
		// round half up: add half the divisor before the division
		n_c     = reach_c ? '0 : (RW'(mag_c[TL_W-1:0]) << F) + RW'(tl_s2 >> 1);
	end

	logic [RW-1:0]   rem_s3;
	logic [TL_W-1:0] tl_s3;
	logic [HVW-1:0]  hsq_s3;
	logic [SIDE_W-1:0] side_s3;
	logic [1:0]      flg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3  <= n_c;
			tl_s3   <= tl_s2;
			hsq_s3  <= {1'b0, hxy_c, 16'b0};
			side_s3 <= {reach_c, dz_s2, dy_s2, dx_s2};
			flg_s3  <= {reach_c, neg_c};
		end
	end

	// ---------------- divider row ----------------
	logic [RW-1:0]   dv_rem [F+2];
	logic [TL_W-1:0] dv_d   [F+2];
	logic [QW-1:0]   dv_q   [F+2];

	assign dv_rem[0] = rem_s3;
	assign dv_d[0]   = tl_s3;
	assign dv_q[0]   = '0;

	for (genvar j = 0; j <= F; j++) begin : g_div
		lik_div_cell #(.RW(RW), .DW(TL_W), .QW(QW), .K(F - j)) u_cell (
			.clk(clk), .en(en),
			.rem_in(dv_rem[j]), .d_in(dv_d[j]), .q_in(dv_q[j]),
			.rem_out(dv_rem[j+1]), .d_out(dv_d[j+1]), .q_out(dv_q[j+1])
		);
	end

	logic [1:0] flg_dv;

	lik_delay #(.W(2), .DEPTH(F + 1)) u_dly_flg (
		.clk(clk), .en(en), .din(flg_s3), .dout(flg_dv)
	);

	// ---------------- stage A: signed acos term ----------------
	logic signed [ARG_W-1:0] arg_sa;

	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_dv[1]) begin
				arg_sa <= ONE_A;
			end else if (flg_dv[0]) begin
				arg_sa <= -$signed({1'b0, dv_q[F+1]});
			end else begin
				arg_sa <= $signed({1'b0, dv_q[F+1]});
			end
		end
	end

	// ---------------- stage B: sine radicand ----------------
	logic signed [2*ARG_W-1:0] asq_c;
	logic [2*F:0]              sd_c;
	logic [2*F+16:0]           kin_sb;

	always_comb begin
		asq_c = arg_sa * arg_sa;
		sd_c  = ONE2 - asq_c[2*F:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kin_sb <= {sd_c, 16'b0};
		end
	end

	// ---------------- square root rows ----------------
	logic [KVW-1:0] kv [KB+1];
	logic [KVW-1:0] kr [KB+1];
	logic [HVW-1:0] hv [H_BITS+1];
	logic [HVW-1:0] hr [H_BITS+1];

	assign kv[0] = KVW'(kin_sb);
	assign kr[0] = '0;
	assign hv[0] = hsq_s3;
	assign hr[0] = '0;

	for (genvar k = 0; k < KB; k++) begin : g_ksqrt
		lik_sqrt_cell #(.NB(KB), .K(k)) u_cell (
			.clk(clk), .en(en), .v_in(kv[k]), .r_in(kr[k]),
			.v_out(kv[k+1]), .r_out(kr[k+1])
		);
	end

	for (genvar k = 0; k < H_BITS; k++) begin : g_hsqrt
		lik_sqrt_cell #(.NB(H_BITS), .K(k)) u_cell (
			.clk(clk), .en(en), .v_in(hv[k]), .r_in(hr[k]),
			.v_out(hv[k+1]), .r_out(hr[k+1])
		);
	end

	// ---------------- alignment to the CORDIC entry ----------------
	logic [SIDE_W-1:0]      side_p;
	logic [H_BITS-1:0]      h_p;
	logic [ARG_W-1:0]       arg_p;

	lik_delay #(.W(SIDE_W), .DEPTH(LAT_K)) u_dly_side (
		.clk(clk), .en(en), .din(side_s3), .dout(side_p)
	);

	lik_delay #(.W(H_BITS), .DEPTH(LAT_K - H_BITS)) u_dly_h (
		.clk(clk), .en(en), .din(hr[H_BITS][H_BITS-1:0]), .dout(h_p)
	);

	lik_delay #(.W(ARG_W), .DEPTH(F + 10)) u_dly_arg (
		.clk(clk), .en(en), .din(arg_sa), .dout(arg_p)
	);

	// ---------------- pre-rotation into the right half plane ----------------
	// lanes: 0 yaw, 1 pitch, 2 knee
	logic signed [CW-1:0] lx [3];
	logic signed [CW-1:0] ly [3];
	logic                 lf [3];
	logic signed [CW-1:0] x_sp [3];
	logic signed [CW-1:0] y_sp [3];
	logic signed [ZW-1:0] z_sp [3];
	logic                 f_sp [3];

	always_comb begin
		lx[0] = CW'($signed({side_p[DIFF_W-1:0], 8'b0}));
		ly[0] = CW'($signed({side_p[2*DIFF_W-1:DIFF_W], 8'b0}));
		lx[1] = $signed(CW'(h_p));
		ly[1] = CW'($signed({side_p[3*DIFF_W-1:2*DIFF_W], 8'b0}));
		lx[2] = CW'($signed({arg_p, 8'b0}));
		ly[2] = $signed(CW'(kr[KB][KB-1:0]));
		// yaw and pitch carry a zero-vector mark, knee carries the reach flag
		lf[0] = (lx[0] == '0) && (ly[0] == '0);
		lf[1] = (lx[1] == '0) && (ly[1] == '0);
		lf[2] = side_p[SIDE_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				f_sp[l] <= lf[l];
				if (lx[l] < 0) begin
					if (ly[l] >= 0) begin
						x_sp[l] <= ly[l];
						y_sp[l] <= -lx[l];
						z_sp[l] <= HP_Z;
					end else begin
						x_sp[l] <= -ly[l];
						y_sp[l] <= lx[l];
						z_sp[l] <= -HP_Z;
					end
				end else begin
					x_sp[l] <= lx[l];
					y_sp[l] <= ly[l];
					z_sp[l] <= '0;
				end
			end
		end
	end

	// ---------------- CORDIC rows ----------------
	logic signed [CW-1:0] cx [3][NS+1];
	logic signed [CW-1:0] cy [3][NS+1];
	logic signed [ZW-1:0] cz [3][NS+1];
	logic                 cf [3][NS+1];
	logic signed [IOW-1:0] io [3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign cx[l][0] = x_sp[l];
		assign cy[l][0] = y_sp[l];
		assign cz[l][0] = z_sp[l];
		assign cf[l][0] = f_sp[l];

		for (genvar i = 0; i < NS; i++) begin : g_rot
			lik_cordic_cell #(.CW(CW), .ZW(ZW), .STAGE(i), .FRAC(F)) u_cell (
				.clk(clk), .en(en),
				.x_in(cx[l][i]), .y_in(cy[l][i]), .z_in(cz[l][i]), .flag_in(cf[l][i]),
				.x_out(cx[l][i+1]), .y_out(cy[l][i+1]), .z_out(cz[l][i+1]),
				.flag_out(cf[l][i+1])
			);
		end

		// round half up to Q.12
		always_comb begin
			io[l] = IOW'(cz[l][NS]) + RND_IO;
			io[l] = io[l] >>> SH_DN;
			io[l] = io[l] <<< SH_UP;
		end
	end

	// ---------------- clamp and pack the result ----------------
	logic signed [IOW-1:0] yaw_c, pitch_c, knee_c;

	always_comb begin
		yaw_c = cf[0][NS] ? '0 : io[0];
		if (yaw_c > PI_IO) yaw_c = PI_IO;
		if (yaw_c < -PI_IO) yaw_c = -PI_IO;
		pitch_c = cf[1][NS] ? '0 : io[1];
		if (pitch_c > HP_IO) pitch_c = HP_IO;
		if (pitch_c < -HP_IO) pitch_c = -HP_IO;
		knee_c = io[2];
		if (knee_c > PI_IO) knee_c = PI_IO;
		if (knee_c < 0) knee_c = '0;
		res_c = {cf[2][NS], knee_c[KNEE_W-1:0], pitch_c[PITCH_W-1:0], yaw_c[YAW_W-1:0]};
	end

	// ---------------- checks ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_q[0])
		else $error("accepted item did not enter the pipeline");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("pipeline moved while held");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_q[TOT-1]) |=> m_tvalid)
		else $error("finished item not offered on the output");

endmodule

### dv/tb_leg_inverse_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_leg_inverse_kinematics: self-checking bench for leg inverse kinematics
// Drives shoulder/foot pairs through a directed table and then random
// geometry over several segment lengths. Every output transfer is checked
// against an in-bench CORDIC angle predictor. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics;
	import lik_pkg::*;

	// field select bits for typed expectations in the directed table
	localparam logic [3:0] FIX_YAW   = 4'b0001;
	localparam logic [3:0] FIX_PITCH = 4'b0010;
	localparam logic [3:0] FIX_KNEE  = 4'b0100;
	localparam logic [3:0] FIX_REACH = 4'b1000;
	localparam int         LATENCY   = 2 * DEF_FRAC_BITS + 12 + DEF_CORDIC_STAGES + 5;

	// atan(2^-i) in Q.30, truncated
	localparam longint ARCTAN_Q30 [16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

	typedef struct packed {
		logic signed [15:0] sx, sy, sz, fx, fy, fz;
	} leg_pose_t;

	typedef struct packed {
		logic signed [YAW_W-1:0]   yaw;
		logic signed [PITCH_W-1:0] pitch;
		logic [KNEE_W-1:0]         knee;
		logic                      reach;
	} leg_angles_t;

	typedef struct {
		leg_pose_t   pose;
		logic [3:0]  fix;
		leg_angles_t angles;
	} pose_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;    // shoulder_x, y, z, foot_x, y, z (16 bits each)
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;    // yaw[14:0], pitch[28:15], knee[42:29], zero fill
	logic [USER_W-1:0]   m_tuser;    // out_of_reach[0]
	logic                cfg_valid;
	logic                cfg_ready;
	logic [SEG_W-1:0]    cfg_data;

	logic [SEG_W-1:0]    seg_len;    // bench copy of segment_length
	leg_angles_t         angle_queue[$];
	int                  mismatches;
	int                  ready_hold;
	logic                burst;      // no idling while set

	leg_inverse_kinematics uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// mostly no gap, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (burst || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// round Q.30 half up to Q.12
	function automatic longint arctan_q12(input longint t);
		return (t + (64'sd1 <<< 17)) >>> 18;
	endfunction

	// vectoring CORDIC arctangent, Q.12 result
	function automatic longint cordic_angle(input longint y, input longint x);
		longint ang, tmp, xs, ys;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			// pre-rotate into the right half plane
			if (y >= 0) begin
				tmp = x; x = y; y = -tmp;
				ang = arctan_q12(64'h6487ED51);
			end else begin
				tmp = x; x = -y; y = tmp;
				ang = -arctan_q12(64'h6487ED51);
			end
		end
		for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; ang = ang + arctan_q12(ARCTAN_Q30[i]);
			end else begin
				x = x - ys; y = y + xs; ang = ang - arctan_q12(ARCTAN_Q30[i]);
			end
		end
		return ang;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic leg_angles_t predict_angles(input leg_pose_t p,
			input logic [SEG_W-1:0] seg);
		leg_angles_t a;
		longint dx, dy, dz, hxy, d2, two_l2, num, mag, q, cosk, horiz, sine;
		longint unsigned rad;
		dx = longint'(p.fx) - longint'(p.sx);
		dy = longint'(p.fy) - longint'(p.sy);
		dz = longint'(p.fz) - longint'(p.sz);
		hxy = dx * dx + dy * dy;
		d2 = hxy + dz * dz;
		two_l2 = 2 * longint'(seg) * longint'(seg);
		num = d2 - two_l2;
		a.reach = 1'b0;
		if (two_l2 == 0 || num > two_l2) begin
			cosk = 4096;
			a.reach = 1'b1;
		end else begin
			mag = (num < 0) ? -num : num;
			q = ((mag <<< 12) + two_l2 / 2) / two_l2;
			if (q > 4096)
				q = 4096;
			cosk = (num < 0) ? -q : q;
		end
		horiz = longint'(int_sqrt(longint'(hxy) << 16));
		rad = longint'(4096 * 4096 - cosk * cosk) << 16;
		sine = longint'(int_sqrt(rad));
		a.yaw = clamp(cordic_angle(dy * 256, dx * 256), -PI_Q12, PI_Q12);
		a.pitch = clamp(cordic_angle(dz * 256, horiz), -HALF_PI_Q12, HALF_PI_Q12);
		a.knee = clamp(cordic_angle(sine, cosk * 256), 0, PI_Q12);
		return a;
	endfunction

	// send one pose; typed fields override the prediction
	task automatic send_pose(input leg_pose_t p, input logic [3:0] fix,
			input leg_angles_t typed);
		leg_angles_t a;
		int gap;
		a = predict_angles(p, seg_len);
		if (fix & FIX_YAW)   a.yaw   = typed.yaw;
		if (fix & FIX_PITCH) a.pitch = typed.pitch;
		if (fix & FIX_KNEE)  a.knee  = typed.knee;
		if (fix & FIX_REACH) a.reach = typed.reach;
		s_tdata <= {p.fz, p.fy, p.fx, p.sz, p.sy, p.sx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		angle_queue.push_back(a);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// write segment_length once the pipeline has drained
	task automatic write_segment(input logic [SEG_W-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_len = v;
	endtask

	// random pose: mostly feet placed near the reach of the current leg
	function automatic leg_pose_t random_pose(input logic [SEG_W-1:0] seg);
		leg_pose_t p;
		int span;
		p = leg_pose_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(99) < 70) begin
			span = 3 * int'(seg) + 16;
			p.sx = $urandom_range(16383) - 8192;
			p.sy = $urandom_range(16383) - 8192;
			p.sz = $urandom_range(16383) - 8192;
			p.fx = p.sx + $urandom_range(2 * span) - span;
			p.fy = p.sy + $urandom_range(2 * span) - span;
			p.fz = p.sz + $urandom_range(2 * span) - span;
		end
		return p;
	endfunction

	// output side: random back-pressure and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				leg_angles_t got, want;
				got.yaw = m_tdata[14:0];
				got.pitch = m_tdata[28:15];
				got.knee = m_tdata[42:29];
				got.reach = m_tuser[0];
				if (angle_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: yaw %0d pitch %0d knee %0d reach %0b",
							got.yaw, got.pitch, got.knee, got.reach);
				end else begin
					want = angle_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp yaw %0d pitch %0d knee %0d reach %0b, got yaw %0d pitch %0d knee %0d reach %0b",
								want.yaw, want.pitch, want.knee, want.reach,
								got.yaw, got.pitch, got.knee, got.reach);
					end
				end
			end
			if (ready_hold > 0) begin
				m_tready <= 1'b0;
				ready_hold--;
			end else begin
				m_tready <= 1'b1;
				ready_hold = pick_gap();
			end
		end
	end

	initial begin
		#20ms;
		$display("leg_inverse_kinematics verification failed");
		$finish;
	end

	initial begin
		pose_row_t     rows[$];
		leg_angles_t   zero_ang;
		logic [SEG_W-1:0] seg_plan[6];
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		seg_len = SEG_RESET;
		mismatches = 0;
		ready_hold = 0;
		burst = 1'b0;
		zero_ang = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset leg length (0.5)
		// zero vector: yaw and pitch read as zero
		rows.push_back('{'{0, 0, 0, 0, 0, 0}, FIX_YAW | FIX_PITCH, zero_ang});
		rows.push_back('{'{100, -200, 300, 100, -200, 300}, FIX_YAW | FIX_PITCH, zero_ang});
		// field extremes, far beyond reach
		rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767},
			FIX_KNEE | FIX_REACH, '{0, 0, 0, 1}});
		rows.push_back('{'{32767, 32767, 32767, -32768, -32768, -32768},
			FIX_KNEE | FIX_REACH, '{0, 0, 0, 1}});
		rows.push_back('{'{-32768, 32767, 0, 32767, -32768, 0}, FIX_KNEE | FIX_REACH, '{0, 0, 0, 1}});
		rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 0, zero_ang});
		// negative x on the axis, both signs of y around it
		rows.push_back('{'{0, 0, 0, -2000, 0, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, -2000, -1, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, -2000, 1, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 0, 3000, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 0, -3000, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 2000, 0, 0}, 0, zero_ang});
		// straight up and down: pitch at its limits
		rows.push_back('{'{0, 0, 0, 0, 0, 3000}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 0, 0, -3000}, 0, zero_ang});
		// exactly at full reach, then one step beyond
		rows.push_back('{'{0, 0, 0, 4096, 0, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 4097, 0, 0}, FIX_KNEE | FIX_REACH, '{0, 0, 0, 1}});
		rows.push_back('{'{0, 0, 0, 0, 0, -4097}, FIX_KNEE | FIX_REACH, '{0, 0, 0, 1}});
		// knee at right angle and nearly folded
		rows.push_back('{'{0, 0, 0, 2896, 0, 0}, 0, zero_ang});
		rows.push_back('{'{0, 0, 0, 1, 1, 1}, 0, zero_ang});
		rows.push_back('{'{1000, 2000, -3000, 2500, 1000, -4000}, 0, zero_ang});
		burst = 1'b1;
		foreach (rows[i]) begin
			if (i == 10)
				burst = 1'b0;
			send_pose(rows[i].pose, rows[i].fix, rows[i].angles);
		end

		// random phases over leg lengths, the extremes and zero among them
		seg_plan = '{13'd1, 13'd8191, 13'd0, 13'd3000, 13'(1 + $urandom_range(8190)), SEG_RESET};
		foreach (seg_plan[k]) begin
			write_segment(seg_plan[k]);
			for (int n = 0; n < 205; n++) begin
				if (n % 50 == 0)
					burst = ($urandom_range(3) == 0);
				send_pose(random_pose(seg_len), 0, zero_ang);
			end
			burst = 1'b0;
		end
		s_tvalid <= 1'b0;

		// drain, then allow stray transfers to show up
		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0)
			$display("leg_inverse_kinematics verification clean");
		else
			$display("leg_inverse_kinematics verification failed");
		$finish;
	end

endmodule

### sim.f
sv/lik_pkg.sv
sv/lik_delay.sv
sv/lik_div_cell.sv
sv/lik_sqrt_cell.sv
sv/lik_cordic_cell.sv
sv/leg_inverse_kinematics.sv
dv/tb_leg_inverse_kinematics.sv
